### hdl/overlay_relay_connection_table_unit_defines.svh
// assertion macros for the relay connection table
`ifndef OVERLAY_RELAY_CONNECTION_TABLE_UNIT_DEFINES_SVH
`define OVERLAY_RELAY_CONNECTION_TABLE_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define OCRT_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("relay table check failed");
`define OCRT_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("relay table check failed");
`else
`define OCRT_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define OCRT_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

### hdl/ocrt_pkg.sv
// shared types and constants of the relay connection table
package ocrt_pkg;
  localparam int NUM_PAIRS_DEF = 16;
  localparam logic [3:0] TIMEOUT_RST = 4'd3;
  localparam int ENTRY_W = 96;

  localparam logic [1:0] OP_SETUP = 2'd0;
  localparam logic [1:0] OP_PKT   = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_ACK  = 2'd1;
  localparam logic [1:0] KIND_REJ  = 2'd2;

  localparam logic [2:0] ACT_REJECT  = 3'd1;
  localparam logic [2:0] ACT_ACK     = 3'd2;
  localparam logic [2:0] ACT_FWD_REQ = 3'd3;
  localparam logic [2:0] ACT_TO_POST = 3'd4;
  localparam logic [2:0] ACT_TO_PRE  = 3'd5;

  // one stored pair: both peers of the relay
  typedef struct packed {
    logic [31:0] pre_ip;
    logic [15:0] pre_peer_port;
    logic [31:0] post_ip;
    logic [15:0] post_peer_port;
  } entry_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] dest_ip;
    logic [15:0] dest_port;
    logic [4:0]  via_channel;
    logic [4:0]  advertised_channel;
    logic [7:0]  hop_out;
    logic        last;
  } result_t;
endpackage

### hdl/ocrt_if.sv
// handshake channels of the relay connection table
interface ocrt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [4:0]  channel;
  logic [31:0] src_ip;
  logic [15:0] src_port;
  logic [1:0]  pkt_kind;
  logic [15:0] ack_port;
  logic [7:0]  hop_count;
  logic        req_length_ok;
  logic [31:0] next_ip;
  logic [15:0] next_port;
  modport source (output valid, op, channel, src_ip, src_port, pkt_kind, ack_port,
                  hop_count, req_length_ok, next_ip, next_port, input ready);
  modport sink (input valid, op, channel, src_ip, src_port, pkt_kind, ack_port,
                hop_count, req_length_ok, next_ip, next_port, output ready);
endinterface

interface ocrt_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [31:0] dest_ip;
  logic [15:0] dest_port;
  logic [4:0]  via_channel;
  logic [4:0]  advertised_channel;
  logic [7:0]  hop_out;
  logic        last;
  modport source (output valid, action, dest_ip, dest_port, via_channel,
                  advertised_channel, hop_out, last, input ready);
  modport sink (input valid, action, dest_ip, dest_port, via_channel,
                advertised_channel, hop_out, last, output ready);
endinterface

interface ocrt_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

### hdl/ocrt_ram.sv
// generic single write, single read ram with registered read
module ocrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### hdl/overlay_relay_connection_table_unit.sv
// relay connection table: pair flags in flops, peer addresses in one ram
// setup result is registered and shown the cycle after accept; packet result follows the ram read in S_RMW
// tick: pairs aged at accept, then each reject goes through S_TICK and S_OUT in turn
// a new item is taken only in S_IDLE, so not before the last result is accepted (output stall holds it)
// reset clears all pair flags and wait counts and sets the timeout to 3 ticks
// address store is not cleared; entries are written at setup before any read
`include "overlay_relay_connection_table_unit_defines.svh"
module overlay_relay_connection_table_unit #(
  parameter int NUM_PAIRS = ocrt_pkg::NUM_PAIRS_DEF
) (
  input logic        clk,
  input logic        rst,
  ocrt_req_if.sink   req,
  ocrt_res_if.source res,
  ocrt_cfg_if.sink   cfg
);
  localparam int PW = (NUM_PAIRS > 1) ? $clog2(NUM_PAIRS) : 1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RMW  = 4'b0010,
    S_TICK = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t state, state_next;
  logic [3:0] timeout_ticks;
  logic [NUM_PAIRS-1:0] used, used_next, up_pend, up_pend_next, dn_pend, dn_pend_next;
  logic [NUM_PAIRS-1:0] tick_mask, tick_mask_next, exp_mask;
  logic [3:0] wcnt [NUM_PAIRS];
  logic [3:0] wcnt_next [NUM_PAIRS];
  logic [3:0] wcnt_inc [NUM_PAIRS];
  ocrt_pkg::result_t rslt, rslt_next;

  // latched packet fields
  logic [4:0]  q_ch;
  logic [31:0] q_sip;
  logic [15:0] q_sport;
  logic [1:0]  q_kind;
  logic [15:0] q_aport;

  logic ram_we;
  logic [PW-1:0] ram_waddr, ram_raddr;
  ocrt_pkg::entry_t ram_wdata, ram_rdata;

  logic [PW-1:0] free_idx, exp_low, mask_low, req_pi, q_pi;
  logic free_found, pkt_hit;

  ocrt_ram #(.WIDTH(ocrt_pkg::ENTRY_W), .DEPTH(NUM_PAIRS)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign res.valid = (state == S_OUT);
  assign res.action = rslt.action;
  assign res.dest_ip = rslt.dest_ip;
  assign res.dest_port = rslt.dest_port;
  assign res.via_channel = rslt.via_channel;
  assign res.advertised_channel = rslt.advertised_channel;
  assign res.hop_out = rslt.hop_out;
  assign res.last = rslt.last;

  assign req_pi = req.channel[PW:1];
  assign q_pi = q_ch[PW:1];
  assign pkt_hit = ({1'b0, req.channel[4:1]} < 5'(NUM_PAIRS)) && used[req_pi];

  // aging, lowest free pair and lowest pending reject
  always_comb begin
    free_found = 1'b0;
    free_idx = '0;
    exp_low = '0;
    mask_low = '0;
    for (int i = NUM_PAIRS - 1; i >= 0; i--) begin
      wcnt_inc[i] = wcnt[i] + 4'd1;
      exp_mask[i] = used[i] && dn_pend[i] && (wcnt_inc[i] == timeout_ticks);
      if (!used[i]) begin
        free_found = 1'b1;
        free_idx = PW'(i);
      end
      if (exp_mask[i]) begin
        exp_low = PW'(i);
      end
      if (tick_mask[i]) begin
        mask_low = PW'(i);
      end
    end
  end

  // read address: packet pair, first expired pair, or next pending reject
  always_comb begin
    if (state == S_IDLE) begin
      ram_raddr = (req.op == ocrt_pkg::OP_TICK) ? exp_low : req_pi;
    end else begin
      ram_raddr = mask_low;
    end
  end

  // next state and table update
  always_comb begin
    state_next = state;
    used_next = used;
    up_pend_next = up_pend;
    dn_pend_next = dn_pend;
    wcnt_next = wcnt;
    tick_mask_next = tick_mask;
    rslt_next = rslt;
    ram_we = 1'b0;
    ram_waddr = q_pi;
    ram_wdata = ram_rdata;
    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          unique case (req.op)
            ocrt_pkg::OP_SETUP: begin
              rslt_next = '0;
              rslt_next.last = 1'b1;
              if (!free_found || !req.req_length_ok) begin
                rslt_next.action = ocrt_pkg::ACT_REJECT;
                rslt_next.dest_ip = req.src_ip;
                rslt_next.dest_port = req.src_port;
              end else begin
                used_next[free_idx] = 1'b1;
                up_pend_next[free_idx] = 1'b1;
                dn_pend_next[free_idx] = (req.hop_count > 8'd1);
                wcnt_next[free_idx] = '0;
                ram_we = 1'b1;
                ram_waddr = free_idx;
                ram_wdata.pre_ip = req.src_ip;
                ram_wdata.pre_peer_port = req.src_port;
                ram_wdata.post_ip = req.next_ip;
                ram_wdata.post_peer_port = (req.hop_count > 8'd1) ? 16'd0 : req.next_port;
                if (req.hop_count > 8'd1) begin
                  rslt_next.action = ocrt_pkg::ACT_FWD_REQ;
                  rslt_next.dest_ip = req.next_ip;
                  rslt_next.dest_port = req.next_port;
                  rslt_next.via_channel = {4'(free_idx), 1'b1};
                  rslt_next.hop_out = req.hop_count - 8'd1;
                end else begin
                  rslt_next.action = ocrt_pkg::ACT_ACK;
                  rslt_next.dest_ip = req.src_ip;
                  rslt_next.dest_port = req.src_port;
                  rslt_next.advertised_channel = {4'(free_idx), 1'b0};
                end
              end
              state_next = S_OUT;
            end
            ocrt_pkg::OP_PKT: begin
              if (pkt_hit) begin
                state_next = S_RMW;
              end
            end
            ocrt_pkg::OP_TICK: begin
              for (int i = 0; i < NUM_PAIRS; i++) begin
                if (used[i] && dn_pend[i]) begin
                  wcnt_next[i] = exp_mask[i] ? 4'd0 : wcnt_inc[i];
                end
              end
              used_next = used & ~exp_mask;
              up_pend_next = up_pend & ~exp_mask;
              dn_pend_next = dn_pend & ~exp_mask;
              tick_mask_next = exp_mask;
              if (exp_mask != '0) begin
                state_next = S_TICK;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_RMW: begin
        rslt_next = '0;
        rslt_next.last = 1'b1;
        state_next = S_IDLE;
        if (q_ch[0] && dn_pend[q_pi] && (q_sip == ram_rdata.post_ip) &&
            (q_kind == ocrt_pkg::KIND_ACK)) begin
          rslt_next.action = ocrt_pkg::ACT_ACK;
          rslt_next.dest_ip = ram_rdata.pre_ip;
          rslt_next.dest_port = ram_rdata.pre_peer_port;
          rslt_next.advertised_channel = {q_ch[4:1], 1'b0};
          ram_we = 1'b1;
          ram_wdata.post_peer_port = q_aport;
          dn_pend_next[q_pi] = 1'b0;
          wcnt_next[q_pi] = '0;
          state_next = S_OUT;
        end else if (q_ch[0] && dn_pend[q_pi] && (q_sip == ram_rdata.post_ip) &&
                     (q_kind == ocrt_pkg::KIND_REJ)) begin
          rslt_next.action = ocrt_pkg::ACT_REJECT;
          rslt_next.dest_ip = ram_rdata.pre_ip;
          rslt_next.dest_port = ram_rdata.pre_peer_port;
          used_next[q_pi] = 1'b0;
          up_pend_next[q_pi] = 1'b0;
          dn_pend_next[q_pi] = 1'b0;
          wcnt_next[q_pi] = '0;
          state_next = S_OUT;
        end else if (!q_ch[0]) begin
          // upstream data; first packet learns the pre port
          if ((q_sip == ram_rdata.pre_ip) && !dn_pend[q_pi]) begin
            if (up_pend[q_pi]) begin
              up_pend_next[q_pi] = 1'b0;
              ram_we = 1'b1;
              ram_wdata.pre_peer_port = q_sport;
            end
            if (up_pend[q_pi] || (ram_rdata.pre_peer_port == q_sport)) begin
              rslt_next.action = ocrt_pkg::ACT_TO_POST;
              rslt_next.dest_ip = ram_rdata.post_ip;
              rslt_next.dest_port = ram_rdata.post_peer_port;
              rslt_next.via_channel = {q_ch[4:1], 1'b1};
              state_next = S_OUT;
            end
          end
        end else begin
          // downstream data
          if ((q_sip == ram_rdata.post_ip) && (q_sport == ram_rdata.post_peer_port) &&
              !up_pend[q_pi]) begin
            rslt_next.action = ocrt_pkg::ACT_TO_PRE;
            rslt_next.dest_ip = ram_rdata.pre_ip;
            rslt_next.dest_port = ram_rdata.pre_peer_port;
            rslt_next.via_channel = {q_ch[4:1], 1'b0};
            state_next = S_OUT;
          end
        end
      end
      S_TICK: begin
        rslt_next = '0;
        rslt_next.action = ocrt_pkg::ACT_REJECT;
        rslt_next.dest_ip = ram_rdata.pre_ip;
        rslt_next.dest_port = ram_rdata.pre_peer_port;
        tick_mask_next = tick_mask & ~(NUM_PAIRS'(1) << mask_low);
        rslt_next.last = (tick_mask_next == '0);
        state_next = S_OUT;
      end
      S_OUT: begin
        if (res.ready) begin
          state_next = (tick_mask != '0) ? S_TICK : S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      timeout_ticks <= ocrt_pkg::TIMEOUT_RST;
      used <= '0;
      up_pend <= '0;
      dn_pend <= '0;
      tick_mask <= '0;
      for (int i = 0; i < NUM_PAIRS; i++) begin
        wcnt[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (cfg.valid) begin
        timeout_ticks <= cfg.data;
      end
      used <= used_next;
      up_pend <= up_pend_next;
      dn_pend <= dn_pend_next;
      tick_mask <= tick_mask_next;
      wcnt <= wcnt_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rslt <= rslt_next;
    if (req.valid && req.ready) begin
      q_ch <= req.channel;
      q_sip <= req.src_ip;
      q_sport <= req.src_port;
      q_kind <= req.pkt_kind;
      q_aport <= req.ack_port;
    end
  end

  `OCRT_ASSERT_IMP(a_tick_has_work, clk, rst, state == S_TICK, tick_mask != '0)
  `OCRT_ASSERT_IMP(a_more_follows, clk, rst, res.valid && !res.last, tick_mask != '0)
  `OCRT_ASSERT_IMP(a_pend_in_use, clk, rst, 1'b1, ((dn_pend | up_pend) & ~used) == '0)
  `OCRT_ASSERT_NXT(a_out_holds, clk, rst, res.valid && !res.ready, res.valid)
endmodule

### verif/overlay_relay_connection_table_unit_checker.sv
// scoreboard of the relay connection table: predicts every result and compares it
module overlay_relay_connection_table_unit_checker (
  input  logic   clk,
  input  logic   rst,
  ocrt_req_if    req,
  ocrt_res_if    res,
  ocrt_cfg_if    cfg,
  output int     mismatches,
  output int     outstanding,
  output int     results_seen
);
  localparam int PAIRS = ocrt_pkg::NUM_PAIRS_DEF;

  // own copy of the table
  logic [3:0]  timeout_limit;
  logic        used_q     [PAIRS];
  logic        pre_learn  [PAIRS];
  logic        post_wait  [PAIRS];
  logic [3:0]  age        [PAIRS];
  logic [31:0] pre_ip_q   [PAIRS];
  logic [15:0] pre_peer_port_q [PAIRS];
  logic [31:0] post_ip_q  [PAIRS];
  logic [15:0] post_peer_port_q[PAIRS];

  ocrt_pkg::result_t awaited_results[$];

  function automatic ocrt_pkg::result_t make_result(logic [2:0] act, logic [31:0] ip,
                                                    logic [15:0] port, logic [4:0] via,
                                                    logic [4:0] adv, logic [7:0] hop);
    ocrt_pkg::result_t r;
    r.action = act;
    r.dest_ip = ip;
    r.dest_port = port;
    r.via_channel = via;
    r.advertised_channel = adv;
    r.hop_out = hop;
    r.last = 1'b0;
    return r;
  endfunction

  function automatic void release_pair(int p);
    used_q[p] = 1'b0;
    pre_learn[p] = 1'b0;
    post_wait[p] = 1'b0;
    age[p] = '0;
  endfunction

  // apply one accepted item to the table and queue the results it causes
  task automatic relay_table_step();
    ocrt_pkg::result_t outs[$];
    ocrt_pkg::result_t r;
    int      free_idx;
    int      p;
    logic    odd;
    logic    answer;
    logic    last_hop;
    free_idx = PAIRS;
    case (req.op)
      ocrt_pkg::OP_SETUP: begin
        for (int i = 0; i < PAIRS; i++)
          if (!used_q[i] && free_idx == PAIRS) free_idx = i;
        if (free_idx == PAIRS || !req.req_length_ok) begin
          outs.push_back(make_result(ocrt_pkg::ACT_REJECT, req.src_ip, req.src_port,
                                     0, 0, 0));
        end else begin
          last_hop = req.hop_count <= 8'd1;
          used_q[free_idx] = 1'b1;
          pre_learn[free_idx] = 1'b1;
          post_wait[free_idx] = !last_hop;
          age[free_idx] = '0;
          pre_ip_q[free_idx] = req.src_ip;
          pre_peer_port_q[free_idx] = req.src_port;
          post_ip_q[free_idx] = req.next_ip;
          post_peer_port_q[free_idx] = last_hop ? req.next_port : 16'd0;
          if (last_hop)
            outs.push_back(make_result(ocrt_pkg::ACT_ACK, req.src_ip, req.src_port, 0,
                                       5'(2 * free_idx), 0));
          else
            outs.push_back(make_result(ocrt_pkg::ACT_FWD_REQ, req.next_ip, req.next_port,
                                       5'(2 * free_idx + 1), 0, req.hop_count - 8'd1));
        end
      end
      ocrt_pkg::OP_PKT: begin
        p = req.channel >> 1;
        if (p < PAIRS && used_q[p]) begin
          odd = req.channel[0];
          answer = odd && post_wait[p] && req.src_ip == post_ip_q[p];
          if (answer && req.pkt_kind == ocrt_pkg::KIND_ACK) begin
            outs.push_back(make_result(ocrt_pkg::ACT_ACK, pre_ip_q[p], pre_peer_port_q[p],
                                       0, 5'(2 * p), 0));
            post_peer_port_q[p] = req.ack_port;
            post_wait[p] = 1'b0;
            age[p] = '0;
          end else if (answer && req.pkt_kind == ocrt_pkg::KIND_REJ) begin
            outs.push_back(make_result(ocrt_pkg::ACT_REJECT, pre_ip_q[p], pre_peer_port_q[p],
                                       0, 0, 0));
            release_pair(p);
          end else if (!odd) begin
            // upstream data; the first one teaches the pre port
            if (req.src_ip == pre_ip_q[p] && !post_wait[p]) begin
              if (pre_learn[p]) begin
                pre_learn[p] = 1'b0;
                pre_peer_port_q[p] = req.src_port;
              end
              if (pre_peer_port_q[p] == req.src_port)
                outs.push_back(make_result(ocrt_pkg::ACT_TO_POST, post_ip_q[p],
                                           post_peer_port_q[p], 5'(2 * p + 1), 0, 0));
            end
          end else begin
            if (req.src_ip == post_ip_q[p] && req.src_port == post_peer_port_q[p] &&
                !pre_learn[p])
              outs.push_back(make_result(ocrt_pkg::ACT_TO_PRE, pre_ip_q[p],
                                         pre_peer_port_q[p], 5'(2 * p), 0, 0));
          end
        end
      end
      ocrt_pkg::OP_TICK: begin
        // age waiting pairs, reject at the timeout in ascending order
        for (int i = 0; i < PAIRS; i++) begin
          if (used_q[i] && post_wait[i]) begin
            age[i] = age[i] + 4'd1;
            if (age[i] == timeout_limit) begin
              outs.push_back(make_result(ocrt_pkg::ACT_REJECT, pre_ip_q[i],
                                         pre_peer_port_q[i], 0, 0, 0));
              release_pair(i);
            end
          end
        end
      end
      default: ;
    endcase
    foreach (outs[k]) begin
      r = outs[k];
      r.last = (k == outs.size() - 1);
      awaited_results.push_back(r);
    end
  endtask

  // compare one result item with the oldest expectation
  task automatic compare_result();
    ocrt_pkg::result_t got;
    ocrt_pkg::result_t want;
    got.action = res.action;
    got.dest_ip = res.dest_ip;
    got.dest_port = res.dest_port;
    got.via_channel = res.via_channel;
    got.advertised_channel = res.advertised_channel;
    got.hop_out = res.hop_out;
    got.last = res.last;
    results_seen++;
    if (awaited_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result item: act=%0d ip=%h port=%h via=%0d adv=%0d hop=%0d last=%b",
                 got.action, got.dest_ip, got.dest_port, got.via_channel,
                 got.advertised_channel, got.hop_out, got.last);
    end else begin
      want = awaited_results.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"result mismatch: expected act=%0d ip=%h port=%h via=%0d adv=%0d hop=%0d ",
                    "last=%b, got act=%0d ip=%h port=%h via=%0d adv=%0d hop=%0d last=%b"},
                   want.action, want.dest_ip, want.dest_port, want.via_channel,
                   want.advertised_channel, want.hop_out, want.last,
                   got.action, got.dest_ip, got.dest_port, got.via_channel,
                   got.advertised_channel, got.hop_out, got.last);
      end
    end
  endtask

  // watch all three channels
  always @(posedge clk) begin
    if (rst) begin
      timeout_limit = ocrt_pkg::TIMEOUT_RST;
      for (int i = 0; i < PAIRS; i++) begin
        release_pair(i);
        pre_ip_q[i] = '0;
        pre_peer_port_q[i] = '0;
        post_ip_q[i] = '0;
        post_peer_port_q[i] = '0;
      end
      awaited_results.delete();
      mismatches = 0;
      results_seen = 0;
    end else begin
      if (cfg.valid && cfg.ready) timeout_limit = cfg.data;
      if (req.valid && req.ready) relay_table_step();
      if (res.valid && res.ready) compare_result();
    end
    outstanding = awaited_results.size();
  end
endmodule

### verif/overlay_relay_connection_table_unit_test.sv
// stimulus and verdict for the relay connection table
module overlay_relay_connection_table_unit_test;
  localparam int RANDOM_ITEMS = 160;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    logic [1:0]  op;
    logic [4:0]  channel;
    logic [31:0] src_ip;
    logic [15:0] src_port;
    logic [1:0]  pkt_kind;
    logic [15:0] ack_port;
    logic [7:0]  hop_count;
    logic        req_length_ok;
    logic [31:0] next_ip;
    logic [15:0] next_port;
  } relay_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   mismatches;
  int   outstanding;
  int   results_seen;
  int   items_sent = 0;
  int   cfg_writes = 0;
  int   burst_left = 0;
  bit   gaps_on = 1'b1;
  int   stall_mode = 0;
  int   cycle_cnt = 0;
  int   idle_cycles = 0;
  logic [31:0] ip_pool[4];
  logic [15:0] port_pool[4];

  ocrt_req_if req ();
  ocrt_res_if res ();
  ocrt_cfg_if cfg ();

  overlay_relay_connection_table_unit dut (
    .clk(clk), .rst(rst), .req(req), .res(res), .cfg(cfg)
  );

  overlay_relay_connection_table_unit_checker scoreboard (
    .clk(clk), .rst(rst), .req(req), .res(res), .cfg(cfg),
    .mismatches(mismatches), .outstanding(outstanding), .results_seen(results_seen)
  );

  always #10 clk = ~clk;

  // result receiver ready follows one of four stall patterns, chosen anew at random periodically
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt % 64 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0:       res.ready <= 1'b1;
      1:       res.ready <= $urandom_range(0, 1);
      2:       res.ready <= (cycle_cnt % 4 == 0);
      default: res.ready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // watchdog on cycles with no accepted item anywhere
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("overlay_relay_connection_table_unit test failed");
      $finish;
    end
  end

  // drive one item, hold until accepted, then maybe leave a gap
  task automatic send_item(relay_item_t it);
    req.valid <= 1'b1;
    req.op <= it.op;
    req.channel <= it.channel;
    req.src_ip <= it.src_ip;
    req.src_port <= it.src_port;
    req.pkt_kind <= it.pkt_kind;
    req.ack_port <= it.ack_port;
    req.hop_count <= it.hop_count;
    req.req_length_ok <= it.req_length_ok;
    req.next_ip <= it.next_ip;
    req.next_port <= it.next_port;
    do @(posedge clk); while (!req.ready);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else if (gaps_on) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(0, 8);
    end
  endtask

  // write the timeout once the table has drained
  task automatic write_timeout(logic [3:0] value);
    req.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.data <= value;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    cfg_writes++;
  endtask

  function automatic relay_item_t build(logic [1:0] op, logic [4:0] ch, logic [31:0] sip,
                                        logic [15:0] sport, logic [1:0] kind,
                                        logic [15:0] aport, logic [7:0] hop, logic ok,
                                        logic [31:0] nip, logic [15:0] nport);
    relay_item_t it;
    it.op = op; it.channel = ch; it.src_ip = sip; it.src_port = sport;
    it.pkt_kind = kind; it.ack_port = aport; it.hop_count = hop;
    it.req_length_ok = ok; it.next_ip = nip; it.next_port = nport;
    return it;
  endfunction

  // addresses mostly from a small pool so that stored peers match often
  function automatic logic [31:0] pick_ip();
    return ($urandom_range(0, 9) == 0) ? $urandom : ip_pool[$urandom_range(0, 3)];
  endfunction

  function automatic logic [15:0] pick_port();
    return ($urandom_range(0, 9) == 0) ? 16'($urandom) : port_pool[$urandom_range(0, 3)];
  endfunction

  function automatic relay_item_t random_item();
    int sel;
    logic [1:0] kind;
    logic [7:0] hop;
    sel = $urandom_range(0, 99);
    kind = ($urandom_range(0, 1) == 0) ? ocrt_pkg::KIND_DATA :
           ($urandom_range(0, 1) == 0) ? ocrt_pkg::KIND_ACK : ocrt_pkg::KIND_REJ;
    hop = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 1)) : 8'($urandom_range(2, 255));
    if (sel < 30)
      return build(ocrt_pkg::OP_SETUP, 5'($urandom), pick_ip(), pick_port(), kind,
                   pick_port(), hop, $urandom_range(0, 9) != 0, pick_ip(), pick_port());
    else if (sel < 90)
      return build(ocrt_pkg::OP_PKT, 5'($urandom_range(0, 31)), pick_ip(), pick_port(), kind,
                   pick_port(), hop, $urandom_range(0, 1), pick_ip(), pick_port());
    else
      return build(ocrt_pkg::OP_TICK, 5'($urandom), $urandom, 16'($urandom), kind,
                   16'($urandom), hop, $urandom_range(0, 1), $urandom, 16'($urandom));
  endfunction

  task automatic random_phase(int count);
    repeat (count) send_item(random_item());
  endtask

  initial begin
    req.valid = 1'b0;
    req.op = ocrt_pkg::OP_TICK;
    req.channel = '0;
    req.src_ip = '0;
    req.src_port = '0;
    req.pkt_kind = ocrt_pkg::KIND_DATA;
    req.ack_port = '0;
    req.hop_count = '0;
    req.req_length_ok = 1'b0;
    req.next_ip = '0;
    req.next_port = '0;
    res.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.data = '0;
    foreach (ip_pool[i]) ip_pool[i] = $urandom;
    foreach (port_pool[i]) port_pool[i] = 16'($urandom);
    ip_pool[0] = 32'hFFFF_FFFF;
    port_pool[0] = 16'h0000;
    port_pool[1] = 16'hFFFF;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: last hop, forward, bad length, answers, data both ways, timeout
    write_timeout(4'd1);
    send_item(build(ocrt_pkg::OP_SETUP, 0, ip_pool[1], port_pool[1], ocrt_pkg::KIND_DATA, 0,
                    8'd0, 1, ip_pool[2], port_pool[2]));
    send_item(build(ocrt_pkg::OP_SETUP, 0, ip_pool[2], port_pool[2], ocrt_pkg::KIND_DATA, 0,
                    8'd1, 1, 32'hFFFF_FFFF, 16'hFFFF));
    send_item(build(ocrt_pkg::OP_SETUP, 0, ip_pool[3], port_pool[3], ocrt_pkg::KIND_DATA, 0,
                    8'd255, 1, ip_pool[1], 16'hFFFF));
    send_item(build(ocrt_pkg::OP_SETUP, 0, 32'h0, 16'h0, ocrt_pkg::KIND_DATA, 0, 8'd4, 1,
                    ip_pool[2], 16'h1234));
    send_item(build(ocrt_pkg::OP_SETUP, 0, 32'hFFFF_FFFF, 16'hFFFF, ocrt_pkg::KIND_DATA, 0,
                    8'd7, 0, 0, 0));
    send_item(build(ocrt_pkg::OP_PKT, 5'd1, ip_pool[2], port_pool[2], ocrt_pkg::KIND_DATA,
                    0, 0, 0, 0, 0));
    send_item(build(ocrt_pkg::OP_PKT, 5'd0, ip_pool[1], 16'h5555, ocrt_pkg::KIND_DATA,
                    0, 0, 0, 0, 0));
    send_item(build(ocrt_pkg::OP_PKT, 5'd0, ip_pool[1], 16'h5555, ocrt_pkg::KIND_DATA,
                    0, 0, 0, 0, 0));
    send_item(build(ocrt_pkg::OP_PKT, 5'd0, ip_pool[1], 16'hAAAA, ocrt_pkg::KIND_DATA,
                    0, 0, 0, 0, 0));
    send_item(build(ocrt_pkg::OP_PKT, 5'd1, ip_pool[2], port_pool[2], ocrt_pkg::KIND_DATA,
                    0, 0, 0, 0, 0));
    send_item(build(ocrt_pkg::OP_PKT, 5'd4, ip_pool[1], 16'h0, ocrt_pkg::KIND_ACK, 16'h4321,
                    0, 0, 0, 0));
    send_item(build(ocrt_pkg::OP_PKT, 5'd5, ip_pool[1], 16'h0, ocrt_pkg::KIND_ACK, 16'h4321,
                    0, 0, 0, 0));
    send_item(build(ocrt_pkg::OP_PKT, 5'd4, 32'h0, 16'h0, ocrt_pkg::KIND_DATA,
                    0, 0, 0, 0, 0));
    send_item(build(ocrt_pkg::OP_PKT, 5'd7, 32'h1, 16'h0, ocrt_pkg::KIND_REJ,
                    0, 0, 0, 0, 0));
    send_item(build(ocrt_pkg::OP_PKT, 5'd7, ip_pool[2], 16'h0, ocrt_pkg::KIND_REJ,
                    0, 0, 0, 0, 0));
    send_item(build(ocrt_pkg::OP_PKT, 5'd31, 32'hFFFF_FFFF, 16'hFFFF, ocrt_pkg::KIND_REJ,
                    16'hFFFF, 8'hFF, 1, 32'hFFFF_FFFF, 16'hFFFF));
    send_item(build(ocrt_pkg::OP_SETUP, 0, ip_pool[3], port_pool[3], ocrt_pkg::KIND_DATA, 0,
                    8'd9, 1, ip_pool[0], 16'h0));
    send_item(build(ocrt_pkg::OP_TICK, 0, 0, 0, ocrt_pkg::KIND_DATA, 0, 0, 0, 0, 0));
    send_item(build(ocrt_pkg::OP_TICK, 0, 0, 0, ocrt_pkg::KIND_DATA, 0, 0, 0, 0, 0));

    // random phases across timeout settings, one without sender gaps
    write_timeout(4'd15);
    random_phase(RANDOM_ITEMS / 4);
    gaps_on = 1'b0;
    write_timeout(4'($urandom_range(2, 14)));
    random_phase(RANDOM_ITEMS / 4);
    gaps_on = 1'b1;
    write_timeout(4'd1);
    random_phase(RANDOM_ITEMS / 4);
    write_timeout(ocrt_pkg::TIMEOUT_RST);
    random_phase(RANDOM_ITEMS / 4);

    // drain
    req.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("relay table run: %0d items sent, %0d results checked, %0d timeout settings",
             items_sent, results_seen, cfg_writes);
    $display("covered setups, answers, data both ways, full table and timeouts");
    if (mismatches == 0 && outstanding == 0)
      $display("overlay_relay_connection_table_unit test passed");
    else
      $display("overlay_relay_connection_table_unit test failed");
    $finish;
  end
endmodule

### files.f
+incdir+hdl
hdl/ocrt_pkg.sv
hdl/ocrt_if.sv
hdl/ocrt_ram.sv
hdl/overlay_relay_connection_table_unit.sv
verif/overlay_relay_connection_table_unit_checker.sv
verif/overlay_relay_connection_table_unit_test.sv
